### hdl/sch_pkg.sv
// ----------------------------------------------------------------------------
// sch_pkg
// Shared types, constants and helpers of the seeded cubehash engine.
// ----------------------------------------------------------------------------
package sch_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_WORDS = 32;
    localparam int HALF      = 16;
    localparam int POS_W     = 7;
    localparam int IDX_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int MAX_COUNT = 64;
    localparam int ROT_A     = 7;
    localparam int ROT_B     = 11;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // commands from the controller to the datapath
    typedef struct packed {
        logic               capture;
        logic               load_init;
        logic               half_round;
        logic               phase;
        logic               xor_en;
        logic               xor_pad;
        logic               flip;
        logic               load_out;
        logic [POS_W-1:0]   pos;
        logic [IDX_W-1:0]   out_index;
        logic               out_last;
        logic [COUNT_W-1:0] init_count;
    } sch_cmd_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int n);
        rotl32 = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

### hdl/sch_datapath.sv
// ----------------------------------------------------------------------------
// sch_datapath
// 1024-bit chaining state with the half-round unit, byte absorb, finalize
// flip and the digest output register.
// ----------------------------------------------------------------------------
module sch_datapath
    import sch_pkg::*;
#(
    parameter int ROUNDS      = 16,
    parameter int BLOCK_BYTES = 32
)
(
    input  logic              clk,
    input  sch_cmd_t          cmd,
    input  logic [7:0]        data_byte,
    input  logic [WORD_W-1:0] hash_seed,
    output logic [7:0]        digest_byte,
    output logic              digest_last
);

    logic [WORD_W-1:0] words_reg  [NUM_WORDS];
    logic [WORD_W-1:0] words_next [NUM_WORDS];
    logic [WORD_W-1:0] ysum       [HALF];
    logic [7:0]        data_reg;
    logic [7:0]        digest_byte_reg;
    logic              digest_last_reg;
    logic [7:0]        absorb_byte;
    logic [WORD_W-1:0] absorb_word;
    logic [WORD_W-1:0] out_word;

    assign absorb_byte = cmd.xor_pad ? PAD_BYTE : data_reg;
    assign absorb_word = WORD_W'(absorb_byte) << {cmd.pos[1:0], 3'b000};

    always_comb
    begin
        for (int k = 0; k < HALF; k++)
        begin
            ysum[k] = words_reg[k + HALF] + words_reg[k];
        end
        words_next = words_reg;
        priority if (cmd.load_init)
        begin
            for (int j = 0; j < NUM_WORDS; j++)
            begin
                words_next[j] = '0;
            end
            words_next[0] = WORD_W'(cmd.init_count);
            words_next[1] = WORD_W'(BLOCK_BYTES);
            words_next[2] = WORD_W'(ROUNDS);
            words_next[3] = hash_seed;
        end
        else if (cmd.half_round)
        begin
            for (int k = 0; k < HALF; k++)
            begin
                if (cmd.phase)
                begin
                    words_next[k]        = rotl32(words_reg[k ^ 4], ROT_B) ^ ysum[k];
                    words_next[k + HALF] = ysum[k ^ 1];
                end
                else
                begin
                    words_next[k]        = rotl32(words_reg[k ^ 8], ROT_A) ^ ysum[k];
                    words_next[k + HALF] = ysum[k ^ 2];
                end
            end
        end
        else if (cmd.xor_en)
        begin
            for (int j = 0; j < NUM_WORDS; j++)
            begin
                if (5'(j) == cmd.pos[6:2])
                begin
                    words_next[j] = words_reg[j] ^ absorb_word;
                end
            end
        end
        else if (cmd.flip)
        begin
            words_next[NUM_WORDS-1] = words_reg[NUM_WORDS-1] ^ WORD_W'(1);
        end
    end

    // byte i of the digest is byte i%4 of word i/4
    assign out_word = words_reg[{1'b0, cmd.out_index[5:2]}] >> {cmd.out_index[1:0], 3'b000};

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
        if (cmd.capture)
        begin
            data_reg <= data_byte;
        end
        if (cmd.load_out)
        begin
            digest_byte_reg <= out_word[7:0];
            digest_last_reg <= cmd.out_last;
        end
    end

    assign digest_byte = digest_byte_reg;
    assign digest_last = digest_last_reg;

endmodule

### hdl/sch_ctrl.sv
// ----------------------------------------------------------------------------
// sch_ctrl
// Sequencer of the engine: input handshake, setup, absorb, transform round
// counter, finalization steps and digest beat emission.
// ----------------------------------------------------------------------------
module sch_ctrl
    import sch_pkg::*;
#(
    parameter int ROUNDS      = 16,
    parameter int BLOCK_BYTES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               byte_present,
    input  logic               message_end,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic [COUNT_W-1:0] digest_bytes,
    output sch_cmd_t           cmd
);

    localparam int PW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int RW = $clog2(2 * ROUNDS);
    localparam logic [PW-1:0] POS_LAST   = PW'(BLOCK_BYTES - 1);
    localparam logic [RW-1:0] ROUND_LAST = RW'(2 * ROUNDS - 1);

    localparam logic [1:0] STEP_PAD  = 2'd0;
    localparam logic [1:0] STEP_FLIP = 2'd1;
    localparam logic [1:0] STEP_LAST = 2'd2;
    localparam logic [1:0] STEP_EMIT = 2'd3;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_INIT  = 7'b0000010,
        ST_XFORM = 7'b0000100,
        ST_BYTE  = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_FLIP  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t             state_reg,      state_next;
    logic [PW-1:0]      pos_reg,        pos_next;
    logic [RW-1:0]      rcnt_reg,       rcnt_next;
    logic [IDX_W-1:0]   idx_reg,        idx_next;
    logic [COUNT_W-1:0] count_reg,      count_next;
    logic               byte_pend_reg,  byte_pend_next;
    logic               end_pend_reg,   end_pend_next;
    logic               setup_pend_reg, setup_pend_next;
    logic [1:0]         step_reg,       step_next;
    logic               out_valid_reg,  out_valid_next;
    logic [COUNT_W-1:0] clamped_count;
    logic               emit_last;
    logic               out_free;

    // what to do next from the pending work
    function automatic state_t pick(input logic bp, input logic ep, input logic ns,
                                    input logic [1:0] st);
        state_t s;
        s = ST_IDLE;
        if (bp)
        begin
            s = ns ? ST_INIT : ST_BYTE;
        end
        else if (ep)
        begin
            if (ns)
            begin
                s = ST_INIT;
            end
            else
            begin
                unique case (st)
                    STEP_PAD:  s = ST_PAD;
                    STEP_FLIP: s = ST_FLIP;
                    default:   s = ST_EMIT;
                endcase
            end
        end
        return s;
    endfunction

    always_comb
    begin
        if (digest_bytes == '0)
        begin
            clamped_count = COUNT_W'(1);
        end
        else if (digest_bytes > COUNT_W'(MAX_COUNT))
        begin
            clamped_count = COUNT_W'(MAX_COUNT);
        end
        else
        begin
            clamped_count = digest_bytes;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_last = ({1'b0, idx_reg} == (count_reg - COUNT_W'(1)));

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        rcnt_next       = rcnt_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        byte_pend_next  = byte_pend_reg;
        end_pend_next   = end_pend_reg;
        setup_pend_next = setup_pend_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && out_stall;

        cmd            = '0;
        cmd.phase      = rcnt_reg[0];
        cmd.pos        = POS_W'(pos_reg);
        cmd.out_index  = idx_reg;
        cmd.out_last   = emit_last;
        cmd.init_count = clamped_count;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    byte_pend_next = byte_present;
                    end_pend_next  = message_end;
                    state_next     = pick(byte_present, message_end, setup_pend_reg, step_reg);
                end
            end
            ST_INIT:
            begin
                cmd.load_init   = 1'b1;
                count_next      = clamped_count;
                setup_pend_next = 1'b0;
                pos_next        = '0;
                rcnt_next       = '0;
                state_next      = ST_XFORM;
            end
            ST_XFORM:
            begin
                cmd.half_round = 1'b1;
                if (rcnt_reg == ROUND_LAST)
                begin
                    rcnt_next = '0;
                    // third finalization transform follows the second directly
                    if (end_pend_reg && step_reg == STEP_LAST)
                    begin
                        step_next = STEP_EMIT;
                    end
                    else
                    begin
                        state_next = pick(byte_pend_reg, end_pend_reg, setup_pend_reg,
                                          step_reg);
                    end
                end
                else
                begin
                    rcnt_next = rcnt_reg + RW'(1);
                end
            end
            ST_BYTE:
            begin
                cmd.xor_en     = 1'b1;
                byte_pend_next = 1'b0;
                if (pos_reg == POS_LAST)
                begin
                    pos_next   = '0;
                    rcnt_next  = '0;
                    state_next = ST_XFORM;
                end
                else
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = pick(1'b0, end_pend_reg, setup_pend_reg, step_reg);
                end
            end
            ST_PAD:
            begin
                cmd.xor_en  = 1'b1;
                cmd.xor_pad = 1'b1;
                step_next   = STEP_FLIP;
                rcnt_next   = '0;
                state_next  = ST_XFORM;
            end
            ST_FLIP:
            begin
                cmd.flip   = 1'b1;
                step_next  = STEP_LAST;
                rcnt_next  = '0;
                idx_next   = '0;
                state_next = ST_XFORM;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (emit_last)
                    begin
                        end_pend_next   = 1'b0;
                        setup_pend_next = 1'b1;
                        step_next       = STEP_PAD;
                        pos_next        = '0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            rcnt_reg       <= '0;
            idx_reg        <= '0;
            count_reg      <= COUNT_W'(MAX_COUNT);
            byte_pend_reg  <= 1'b0;
            end_pend_reg   <= 1'b0;
            setup_pend_reg <= 1'b1;
            step_reg       <= STEP_PAD;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            rcnt_reg       <= rcnt_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            byte_pend_reg  <= byte_pend_next;
            end_pend_reg   <= end_pend_next;
            setup_pend_reg <= setup_pend_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/seeded_cubehash_engine_core.sv
// ----------------------------------------------------------------------------
// seeded_cubehash_engine_core
// Byte-stream CubeHash engine with a configurable seed word and digest length.
// ----------------------------------------------------------------------------
// One input beat carries at most one message byte and an end-of-message flag.
// A plain byte beat is captured, then absorbed in the byte state; the beat
// that completes a block of BLOCK_BYTES bytes adds one transform of 2*ROUNDS
// half-rounds, since the shared round unit does one half-round per cycle. The
// first beat of a message adds the setup: the initial state load, then one
// transform. An end beat adds padding and three transforms, with the flip
// after the first, then one digest beat per cycle while the output side takes
// them; a new input beat is accepted as soon as the last digest beat is in the
// output register. digest_bytes and hash_seed are sampled at the setup of each
// message; a digest_bytes of 0 acts as 1 and values above 64 act as 64.
module seeded_cubehash_engine_core
    import sch_pkg::*;
#(
    parameter int ROUNDS      = 16,
    parameter int BLOCK_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  digest_byte,
    output logic        digest_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_DIGEST_BYTES = 1'b0;
    localparam logic REG_HASH_SEED    = 1'b1;

    logic [COUNT_W-1:0] digest_bytes_reg;
    logic [WORD_W-1:0]  hash_seed_reg;
    logic               cfg_write;
    sch_cmd_t           cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_bytes_reg <= COUNT_W'(MAX_COUNT);
            hash_seed_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_DIGEST_BYTES: digest_bytes_reg <= pwdata[COUNT_W-1:0];
                REG_HASH_SEED:    hash_seed_reg    <= pwdata;
                default:          hash_seed_reg    <= hash_seed_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DIGEST_BYTES: prdata = 32'(digest_bytes_reg);
            REG_HASH_SEED:    prdata = hash_seed_reg;
            default:          prdata = '0;
        endcase
    end

    sch_ctrl #(
        .ROUNDS      (ROUNDS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_present (byte_present),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_bytes (digest_bytes_reg),
        .cmd          (cmd)
    );

    sch_datapath #(
        .ROUNDS      (ROUNDS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .hash_seed   (hash_seed_reg),
        .digest_byte (digest_byte),
        .digest_last (digest_last)
    );

    // a new digest beat never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || !out_stall))
        else $error("digest beat overwritten");

    // the round unit never shares a cycle with another state update
    a_round_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.half_round |-> !(cmd.load_init || cmd.xor_en || cmd.flip || cmd.load_out))
        else $error("round overlaps another state update");

    // a beat that carries work makes the engine busy
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (byte_present || message_end)) |=> in_stall)
        else $error("engine idle after a working beat");

    // absorb position stays inside the block
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.xor_en && !cmd.xor_pad) |-> (32'(cmd.pos) < 32'(BLOCK_BYTES)))
        else $error("absorb position outside block");

endmodule

### bench/tb_seeded_cubehash_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seeded_cubehash_engine_core
// Self-checking bench for the byte-stream cubehash engine: random messages
// with random beat gaps and output stalls, digest length and seed swept over
// the register port, every digest beat compared against an in-bench model.
// ----------------------------------------------------------------------------
module tb_seeded_cubehash_engine_core;
    import sch_pkg::*;

    localparam int ROUNDS_N = 16;
    localparam int BLOCK_N  = 32;
    localparam int SETTLE   = 8 * ROUNDS_N + 40;
    localparam int RAND_BEATS = 430;

    localparam logic [2:0] ADDR_DIGEST_BYTES = 3'd0;
    localparam logic [2:0] ADDR_HASH_SEED    = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
    } msg_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        message_end;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  digest_byte;
    logic        digest_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // stimulus and expectation stores
    msg_beat_t    beats_waiting [$];
    digest_beat_t digest_due [$];
    int           beats_queued = 0;
    int           beats_taken  = 0;
    int           errors       = 0;
    logic         in_fire;
    logic         quiet = 1'b0;

    // model of the hash state
    logic [31:0]  cube [32];
    int           blk_pos;
    logic         fresh;
    logic [6:0]   cfg_len;
    logic [31:0]  cfg_seed;
    int           msg_len;

    seeded_cubehash_engine_core #(
        .ROUNDS      (ROUNDS_N),
        .BLOCK_BYTES (BLOCK_N)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_byte  (digest_byte),
        .digest_last  (digest_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic cube_rounds();
        logic [31:0] t [16];
        for (int r = 0; r < ROUNDS_N; r++)
        begin
            for (int k = 0; k < 16; k++) cube[k + 16] += cube[k];
            for (int k = 0; k < 16; k++) t[k ^ 8] = cube[k];
            for (int k = 0; k < 16; k++)
                cube[k] = {t[k][31-ROT_A:0], t[k][31:32-ROT_A]} ^ cube[k + 16];
            for (int k = 0; k < 16; k++) t[k ^ 2] = cube[k + 16];
            for (int k = 0; k < 16; k++) cube[k + 16] = t[k];
            for (int k = 0; k < 16; k++) cube[k + 16] += cube[k];
            for (int k = 0; k < 16; k++) t[k ^ 4] = cube[k];
            for (int k = 0; k < 16; k++)
                cube[k] = {t[k][31-ROT_B:0], t[k][31:32-ROT_B]} ^ cube[k + 16];
            for (int k = 0; k < 16; k++) t[k ^ 1] = cube[k + 16];
            for (int k = 0; k < 16; k++) cube[k + 16] = t[k];
        end
    endtask

    task automatic cube_setup();
        int n;
        n = int'(cfg_len);
        if (n < 1)
            n = 1;
        else if (n > MAX_COUNT)
            n = MAX_COUNT;
        msg_len = n;
        for (int i = 0; i < 32; i++) cube[i] = '0;
        cube[0] = n;
        cube[1] = BLOCK_N;
        cube[2] = ROUNDS_N;
        cube[3] = cfg_seed;
        cube_rounds();
        blk_pos = 0;
        fresh = 1'b0;
    endtask

    task automatic absorb(input logic [7:0] b);
        cube[blk_pos >> 2] ^= 32'(b) << (8 * (blk_pos & 3));
    endtask

    // advance the hash state by one beat, queue any digest it produces
    task automatic hash_beat(input msg_beat_t bt);
        logic [31:0] w;
        if (bt.present)
        begin
            if (fresh) cube_setup();
            absorb(bt.data);
            blk_pos++;
            if (blk_pos >= BLOCK_N)
            begin
                cube_rounds();
                blk_pos = 0;
            end
        end
        if (bt.fin)
        begin
            if (fresh) cube_setup();
            absorb(PAD_BYTE);
            cube_rounds();
            cube[31] ^= 32'd1;
            cube_rounds();
            cube_rounds();
            for (int i = 0; i < msg_len; i++)
            begin
                w = cube[i / 4] >> (8 * (i % 4));
                digest_due.push_back('{data: w[7:0], last: (i + 1 == msg_len)});
            end
            blk_pos = 0;
            fresh = 1'b1;
        end
    endtask

    task automatic add_beat(input logic [7:0] b, input logic pres, input logic fin);
        beats_waiting.push_back('{data: b, present: pres, fin: fin});
        beats_queued++;
    endtask

    // glue puts the end flag on the last byte beat instead of a beat of its own
    task automatic add_message(input int nbytes, input bit glue);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(99) < 8) add_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            add_beat(8'($urandom_range(255)), 1'b1, glue && (i == nbytes - 1));
        end
        if (!glue || nbytes == 0) add_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_DIGEST_BYTES)
            cfg_len = val[6:0];
        else
            cfg_seed = val;
    endtask

    task automatic wait_quiet();
        while (!(beats_taken == beats_queued && digest_due.size() == 0)) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        msg_beat_t bt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (beats_waiting.size() != 0 && (quiet || $urandom_range(99) >= 28))
            begin
                bt = beats_waiting.pop_front();
                in_valid     <= 1'b1;
                data_byte    <= bt.data;
                byte_present <= bt.present;
                message_end  <= bt.fin;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 28);
    end

    // monitor: check digest beats, feed accepted input beats to the model
    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (digest_due.size() == 0)
                begin
                    flag("unexpected digest beat", 32'(digest_byte), 32'd0);
                end
                else
                begin
                    want = digest_due.pop_front();
                    if (digest_byte !== want.data)
                        flag("digest_byte", 32'(digest_byte), 32'(want.data));
                    if (digest_last !== want.last)
                        flag("digest_last", 32'(digest_last), 32'(want.last));
                end
            end
            if (in_valid && !in_stall)
            begin
                hash_beat('{data: data_byte, present: byte_present, fin: message_end});
                beats_taken++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int phase;
        int nb;
        logic [6:0] len;
        logic [31:0] seed;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = '0;
        byte_present = 1'b0;
        message_end  = 1'b0;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        blk_pos      = 0;
        fresh        = 1'b1;
        cfg_len      = 7'd64;
        cfg_seed     = '0;
        msg_len      = 64;
        for (int i = 0; i < 32; i++) cube[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: idle beat, empty message, one-byte message, short ones
        add_beat(8'hFF, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);
        add_beat(8'hFF, 1'b1, 1'b1);
        add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'hFF, 1'b1, 1'b0);
        add_beat(8'h3C, 1'b0, 1'b0);
        add_beat(8'h5A, 1'b1, 1'b0);
        add_beat(8'hA5, 1'b1, 1'b1);
        add_beat(8'hFF, 1'b0, 1'b1);
        wait_quiet();

        // zero length acts as one
        reg_write(ADDR_DIGEST_BYTES, 32'd0);
        reg_write(ADDR_HASH_SEED, 32'hFFFF_FFFF);
        add_beat(8'h01, 1'b1, 1'b0);
        add_beat(8'h80, 1'b1, 1'b0);
        add_beat(8'hFE, 1'b1, 1'b0);
        add_beat(8'h00, 1'b0, 1'b1);
        wait_quiet();

        // above range acts as 64
        reg_write(ADDR_DIGEST_BYTES, 32'd127);
        reg_write(ADDR_HASH_SEED, 32'h1234_5678);
        add_beat(8'h7F, 1'b0, 1'b1);
        wait_quiet();

        reg_write(ADDR_DIGEST_BYTES, 32'd1);
        add_beat(8'hC3, 1'b1, 1'b0);
        add_beat(8'h3C, 1'b1, 1'b1);
        wait_quiet();

        reg_write(ADDR_DIGEST_BYTES, 32'd65);
        reg_write(ADDR_HASH_SEED, 32'd0);
        add_beat(8'h55, 1'b1, 1'b1);
        wait_quiet();

        reg_write(ADDR_DIGEST_BYTES, 32'd64);
        add_beat(8'hAA, 1'b1, 1'b1);
        wait_quiet();

        // random part: one register setting per phase
        phase = 0;
        while (beats_queued < RAND_BEATS)
        begin
            case ($urandom_range(5))
                0: len = 7'd1;
                1: len = 7'd64;
                2: len = 7'd0;
                3: len = 7'($urandom_range(65, 127));
                default: len = 7'($urandom_range(1, 64));
            endcase
            case ($urandom_range(3))
                0: seed = 32'd0;
                1: seed = 32'hFFFF_FFFF;
                default: seed = $urandom;
            endcase
            reg_write(ADDR_DIGEST_BYTES, {25'd0, len});
            reg_write(ADDR_HASH_SEED, seed);
            quiet = (phase == 1);
            for (int m = 0; m < 5 && beats_queued < RAND_BEATS; m++)
            begin
                case ($urandom_range(9))
                    0: nb = 0;
                    1, 2: nb = $urandom_range(32, 40);
                    3: nb = $urandom_range(60, 70);
                    default: nb = $urandom_range(1, 31);
                endcase
                add_message(nb, 1'($urandom_range(1)));
                // sender holds off until the engine has drained
                if (phase == 0 && m == 1) wait_quiet();
            end
            wait_quiet();
            phase++;
        end
        quiet = 1'b0;

        wait_quiet();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### seeded_cubehash_engine_core.f
hdl/sch_pkg.sv
hdl/sch_datapath.sv
hdl/sch_ctrl.sv
hdl/seeded_cubehash_engine_core.sv
bench/tb_seeded_cubehash_engine_core.sv
